[hdl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    // Queue depth and fixed field widths of the request and response beats.
    localparam int SPQ_DEPTH  = 16;
    localparam int SPQ_KEY_W  = 16;
    localparam int SPQ_DATA_W = 32;
    localparam int SPQ_CNT_W  = 5;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_PURGE  = 2'd2,
        REQ_NOP    = 2'd3
    } req_code_t;

    // Status codes carried in the response.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_UNUSED     = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [SPQ_KEY_W-1:0]  priority_key;
        logic [SPQ_DATA_W-1:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  is_empty;
        logic [SPQ_CNT_W-1:0]  entry_count;
        logic [SPQ_KEY_W-1:0]  front_key;
        logic [SPQ_DATA_W-1:0] front_data;
        logic [SPQ_KEY_W-1:0]  back_key;
        logic [SPQ_DATA_W-1:0] back_data;
    } res_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell #(
    parameter int KEY_W  = 16,
    parameter int DATA_W = 32
) (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occ,
    input  logic [KEY_W-1:0]    new_key,
    input  logic [DATA_W-1:0]   new_data,
    input  logic                left_flag,
    input  logic [KEY_W-1:0]    left_key,
    input  logic [DATA_W-1:0]   left_data,
    input  logic [KEY_W-1:0]    right_key,
    input  logic [DATA_W-1:0]   right_data,
    output logic                flag,
    output logic [KEY_W-1:0]    key,
    output logic [DATA_W-1:0]   data
);
    import spq_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // The new entry belongs at or ahead of this slot when the slot is free
    // or holds a smaller key. Along the sorted chain this flag is monotonic.
    assign flag = !occ || (key_reg < new_key);

    // Insert: the first flagged cell takes the new entry, later ones shift
    // back. Remove: every cell takes its right neighbor.
    always_comb
    begin
        key_next  = key_reg;
        data_next = data_reg;
        if (ctrl.ins && flag)
        begin
            if (left_flag)
            begin
                key_next  = left_key;
                data_next = left_data;
            end
            else
            begin
                key_next  = new_key;
                data_next = new_data;
            end
        end
        else if (ctrl.rem)
        begin
            key_next  = right_key;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key  = key_reg;
    assign data = data_reg;

endmodule

[hdl/sorted_priority_queue.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Beat
// request   in         start high while busy low   req (req_t)
// response  out        done high for one cycle     res (res_t)
//
// One request is taken every cycle; busy stays low. Each request gives one
// response beat on the next cycle, when the chain of cells has shifted.
// The insert position is found by all cells comparing in parallel as the
// request is taken. Reset clears count, done and status; slots need none.
// The receiver cannot stall: done pulses for exactly one cycle per request.

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          done,
    output spq_pkg::res_t res
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             done_reg;
    status_code_t     status_reg;
    status_code_t     status_next;
    cell_ctrl_t       ctrl;
    logic             accept;
    logic             full;
    logic             empty;

    logic [DEPTH-1:0]      occ;
    logic [DEPTH-1:0]      flags;
    logic [DEPTH-1:0]      last;
    logic [SPQ_KEY_W-1:0]  keys  [DEPTH];
    logic [SPQ_DATA_W-1:0] datas [DEPTH];
    logic [SPQ_KEY_W-1:0]  back_key;
    logic [SPQ_DATA_W-1:0] back_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // Decode the request into chain commands, count update and status.
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        if (accept)
        begin
            unique case (req_code_t'(req.req_type))
                REQ_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.rem   = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                REQ_PURGE:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    // Row of cells, slot 0 at the front.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                  lf;
        logic [SPQ_KEY_W-1:0]  lk;
        logic [SPQ_DATA_W-1:0] ld;
        logic [SPQ_KEY_W-1:0]  rk;
        logic [SPQ_DATA_W-1:0] rd;

        assign occ[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign lf = 1'b0;
            assign lk = req.priority_key;
            assign ld = req.entry_payload;
        end
        else
        begin : g_body
            assign lf = flags[i-1];
            assign lk = keys[i-1];
            assign ld = datas[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rk = keys[i];
            assign rd = datas[i];
            assign last[i] = occ[i];
        end
        else
        begin : g_mid
            assign rk = keys[i+1];
            assign rd = datas[i+1];
            assign last[i] = occ[i] && !occ[i+1];
        end

        spq_cell #(
            .KEY_W  (SPQ_KEY_W),
            .DATA_W (SPQ_DATA_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ[i]),
            .new_key    (req.priority_key),
            .new_data   (req.entry_payload),
            .left_flag  (lf),
            .left_key   (lk),
            .left_data  (ld),
            .right_key  (rk),
            .right_data (rd),
            .flag       (flags[i]),
            .key        (keys[i]),
            .data       (datas[i])
        );
    end

    // Back entry: the single occupied cell whose right neighbor is free.
    always_comb
    begin
        back_key  = '0;
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_key  = back_key  | (keys[i]  & {SPQ_KEY_W{last[i]}});
            back_data = back_data | (datas[i] & {SPQ_DATA_W{last[i]}});
        end
    end

    // Response beat, shown on the cycle after the request.
    always_comb
    begin
        res             = '0;
        res.status      = status_reg;
        res.is_empty    = empty;
        res.entry_count = SPQ_CNT_W'(count_reg);
        if (!empty)
        begin
            res.front_key  = keys[0];
            res.front_data = datas[0];
            res.back_key   = back_key;
            res.back_data  = back_data;
        end
    end

    assign done = done_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          DRAIN_CYCLES = 5;

    // One row of the directed table. When typed is set, view is the
    // expected response; otherwise the queue model supplies it.
    typedef struct {
        req_t beat;
        bit   typed;
        res_t view;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    req_t req_bus = '0;
    res_t res_bus;

    // Software copy of the sorted queue: slot 0 is the front.
    logic [SPQ_KEY_W-1:0]  model_keys [SPQ_DEPTH];
    logic [SPQ_DATA_W-1:0] model_data [SPQ_DEPTH];
    int                    model_fill = 0;

    // Responses still owed by the block, oldest first.
    res_t        expected_views [$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    dir_row_t dir_table [25] = '{
        // Remove, purge and no-op on an empty queue.
        '{'{REQ_REMOVE, 16'h0000, 32'h0000_0000}, 1'b1,
          '{ST_EMPTY, 1'b1, 5'd0, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}},
        '{'{REQ_PURGE, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_OK, 1'b1, 5'd0, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}},
        '{'{REQ_NOP, 16'h1234, 32'h89AB_CDEF}, 1'b1,
          '{ST_OK, 1'b1, 5'd0, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}},
        // Largest and smallest keys and payloads.
        '{'{REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_OK, 1'b0, 5'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}},
        '{'{REQ_INSERT, 16'h0000, 32'h0000_0000}, 1'b1,
          '{ST_OK, 1'b0, 5'd2, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000}},
        // Equal keys must come out in arrival order.
        '{'{REQ_INSERT, 16'h8000, 32'hA5A5_A5A5}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h8000, 32'h5A5A_5A5A}, 1'b0, '0},
        '{'{REQ_NOP, 16'h0F0F, 32'h0F0F_0F0F}, 1'b0, '0},
        '{'{REQ_REMOVE, 16'h0000, 32'h0000_0000}, 1'b0, '0},
        // Fill the queue up to its depth.
        '{'{REQ_INSERT, 16'h0001, 32'h0000_0001}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h8000, 32'h8000_0000}, 1'b0, '0},
        '{'{REQ_INSERT, 16'hFFFF, 32'h1111_1111}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h0000, 32'h2222_2222}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h1234, 32'h3333_3333}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h00FF, 32'h4444_4444}, 1'b0, '0},
        '{'{REQ_INSERT, 16'hFF00, 32'h5555_5555}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h7FFF, 32'h6666_6666}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h8001, 32'h7777_7777}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h0000, 32'h9999_9999}, 1'b0, '0},
        '{'{REQ_INSERT, 16'hFFFE, 32'hAAAA_AAAA}, 1'b0, '0},
        '{'{REQ_INSERT, 16'h5555, 32'hBBBB_BBBB}, 1'b0, '0},
        '{'{REQ_INSERT, 16'hAAAA, 32'hCCCC_CCCC}, 1'b0, '0},
        // Insert into a full queue, then remove and purge.
        '{'{REQ_INSERT, 16'hFFFF, 32'hDEAD_BEEF}, 1'b0, '0},
        '{'{REQ_REMOVE, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{REQ_PURGE, 16'h0000, 32'h0000_0000}, 1'b1,
          '{ST_OK, 1'b1, 5'd0, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000}}
    };

    sorted_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req_bus),
        .done  (done),
        .res   (res_bus)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one request to the queue model and returns the view after it.
    function automatic res_t queue_apply(req_t beat);
        res_t view;
        int   pos;
        view = '0;
        view.status = ST_OK;
        case (beat.req_type)
            REQ_INSERT:
            begin
                if (model_fill >= SPQ_DEPTH)
                begin
                    view.status = ST_FULL;
                end
                else
                begin
                    // New entry goes ahead of the first strictly smaller key.
                    pos = model_fill;
                    for (int i = 0; i < model_fill; i++)
                    begin
                        if (model_keys[i] < beat.priority_key)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = model_fill; i > pos; i--)
                    begin
                        model_keys[i] = model_keys[i-1];
                        model_data[i] = model_data[i-1];
                    end
                    model_keys[pos] = beat.priority_key;
                    model_data[pos] = beat.entry_payload;
                    model_fill++;
                end
            end
            REQ_REMOVE:
            begin
                if (model_fill == 0)
                begin
                    view.status = ST_EMPTY;
                end
                else
                begin
                    for (int i = 1; i < model_fill; i++)
                    begin
                        model_keys[i-1] = model_keys[i];
                        model_data[i-1] = model_data[i];
                    end
                    model_fill--;
                end
            end
            REQ_PURGE:
            begin
                model_fill = 0;
            end
            default:
            begin
            end
        endcase
        view.is_empty    = (model_fill == 0);
        view.entry_count = model_fill[SPQ_CNT_W-1:0];
        if (model_fill != 0)
        begin
            view.front_key  = model_keys[0];
            view.front_data = model_data[0];
            view.back_key   = model_keys[model_fill-1];
            view.back_data  = model_data[model_fill-1];
        end
        return view;
    endfunction

    // Random request; ins_pct steers how fast the queue fills.
    function automatic req_t random_request(int ins_pct);
        req_t beat;
        int   roll;
        beat.entry_payload = $urandom;
        case ($urandom_range(3))
            0: beat.priority_key = SPQ_KEY_W'($urandom_range(7));
            1:
            begin
                case ($urandom_range(3))
                    0: beat.priority_key = 16'h0000;
                    1: beat.priority_key = 16'h7FFF;
                    2: beat.priority_key = 16'h8000;
                    default: beat.priority_key = 16'hFFFF;
                endcase
            end
            default: beat.priority_key = SPQ_KEY_W'($urandom);
        endcase
        roll = $urandom_range(99);
        if (roll < 2)
            beat.req_type = REQ_PURGE;
        else if (roll < 4)
            beat.req_type = REQ_NOP;
        else if (roll < 4 + (ins_pct * 96) / 100)
            beat.req_type = REQ_INSERT;
        else
            beat.req_type = REQ_REMOVE;
        return beat;
    endfunction

    // Gap before the next request: mostly none, some short, a few long.
    function automatic int pick_gap(bit quiet);
        if (quiet || $urandom_range(9) < 7)
            return 0;
        if ($urandom_range(4) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Presents one request beat and waits until the block takes it.
    task automatic send_beat(req_t beat, bit typed, res_t typed_view);
        res_t view;
        start   <= 1'b1;
        req_bus <= beat;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        view = queue_apply(beat);
        expected_views.push_back(typed ? typed_view : view);
    endtask

    // Holds start low for a number of cycles with junk on the request bus.
    task automatic hold_idle(int cycles);
        logic [63:0] junk;
        junk    = {$urandom, $urandom};
        start   <= 1'b0;
        req_bus <= junk[$bits(req_t)-1:0];
        repeat (cycles) @(posedge clk);
    endtask

    // Stimulus: directed table, then segments of random requests.
    initial
    begin
        int gap;
        int sent;
        int seg_len;
        int ins_pct;
        bit quiet;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].view);
            gap = pick_gap(1'b0);
            if (gap != 0)
                hold_idle(gap);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(3))
                0: ins_pct = 20;
                1: ins_pct = 50;
                2: ins_pct = 80;
                default: ins_pct = 95;
            endcase
            quiet = ($urandom_range(3) == 0);
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++)
            begin
                send_beat(random_request(ins_pct), 1'b0, '0);
                sent++;
                gap = pick_gap(quiet);
                if (gap != 0)
                    hold_idle(gap);
            end
        end
        start <= 1'b0;

        // Drain outstanding responses, then allow a few extra cycles.
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Response checker: every done beat is matched against the oldest view.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_views.size() == 0)
            begin
                $error("response beat with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_views.pop_front();
                if (res_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    mismatches++;
                end
                if (res_bus.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, res_bus.is_empty);
                    mismatches++;
                end
                if (res_bus.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, res_bus.entry_count);
                    mismatches++;
                end
                if (res_bus.front_key !== want.front_key)
                begin
                    $error("front_key: expected %h, got %h", want.front_key, res_bus.front_key);
                    mismatches++;
                end
                if (res_bus.front_data !== want.front_data)
                begin
                    $error("front_data: expected %h, got %h",
                           want.front_data, res_bus.front_data);
                    mismatches++;
                end
                if (res_bus.back_key !== want.back_key)
                begin
                    $error("back_key: expected %h, got %h", want.back_key, res_bus.back_key);
                    mismatches++;
                end
                if (res_bus.back_data !== want.back_data)
                begin
                    $error("back_data: expected %h, got %h", want.back_data, res_bus.back_data);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
dv/testbench.sv
